>>> hw/rtl/srfl_pkg.sv
package srfl_pkg;

  // Limiter selection held in the configuration register
  typedef enum logic {
    LIM_MINBEE   = 1'b0,
    LIM_VAN_LEER = 1'b1
  } lim_sel_t;

endpackage

>>> hw/rtl/srfl_front.sv
module srfl_front #(
  parameter int VW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srfl_pkg::lim_sel_t    lim_sel,
  input  logic                  up_valid,
  output logic                  up_take,
  input  logic signed [VW-1:0]  left_value,
  input  logic signed [VW-1:0]  centre_value,
  input  logic signed [VW-1:0]  right_value,
  input  logic                  down_take,
  output logic                  dn_valid,
  output logic [VW+1:0]         dn_num,
  output logic [VW+1:0]         dn_den
);
  import srfl_pkg::*;

  localparam int DW = VW + 2;

  logic [2:0] v_r, v_nxt;
  logic [2:0] take;

  // Stage A: upstream and downstream differences
  logic signed [VW:0] a_r, b_r;
  // Stage B: magnitudes and sign / zero flags
  logic [VW:0] ua_r, ub_r;
  logic        sa_r, sb_r, za_r, zb_r;
  // Stage C: divider operands
  logic [DW-1:0] num_r, num_nxt, den_r, den_nxt;

  logic [DW-1:0] ua_ext, ub_ext, sum;
  logic          a_le_b, positive;

  // Collapse bubbles: a stage loads when empty or when it drains downstream
  assign take[2] = !v_r[2] || down_take;
  assign take[1] = !v_r[1] || take[2];
  assign take[0] = !v_r[0] || take[1];
  assign up_take = take[0];

  always_comb begin
    v_nxt[0] = take[0] ? up_valid : v_r[0];
    v_nxt[1] = take[1] ? v_r[0]   : v_r[1];
    v_nxt[2] = take[2] ? v_r[1]   : v_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      a_r <= {centre_value[VW-1], centre_value} - {left_value[VW-1], left_value};
      b_r <= {right_value[VW-1], right_value} - {centre_value[VW-1], centre_value};
    end
  end

  always_ff @(posedge clk) begin
    if (take[1]) begin
      ua_r <= a_r[VW] ? (VW+1)'(-a_r) : a_r;
      ub_r <= b_r[VW] ? (VW+1)'(-b_r) : b_r;
      sa_r <= a_r[VW];
      sb_r <= b_r[VW];
      za_r <= (a_r == '0);
      zb_r <= (b_r == '0);
    end
  end

  assign ua_ext   = {1'b0, ua_r};
  assign ub_ext   = {1'b0, ub_r};
  assign sum      = ua_ext + ub_ext;
  assign a_le_b   = (ua_r <= ub_r);
  assign positive = !za_r && !zb_r && (sa_r == sb_r);

  // A non-positive ratio divides zero by one, which yields zero
  always_comb begin
    num_nxt = '0;
    den_nxt = DW'(1);
    if (positive) begin
      if (lim_sel == LIM_MINBEE && a_le_b) begin
        num_nxt = ua_ext;
        den_nxt = ub_ext;
      end else begin
        num_nxt = a_le_b ? {ua_r, 1'b0} : {ub_r, 1'b0};
        den_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take[2]) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
  end

  assign dn_valid = v_r[2];
  assign dn_num   = num_r;
  assign dn_den   = den_r;

endmodule

>>> hw/rtl/srfl_div_cell.sv
module srfl_div_cell #(
  parameter int RW    = 34,
  parameter int QW    = 17,
  parameter bit SHIFT = 1'b1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_take,
  input  logic [RW-1:0] up_rem,
  input  logic [RW-1:0] up_den,
  input  logic [QW-1:0] up_quo,
  input  logic          down_take,
  output logic          dn_valid,
  output logic [RW-1:0] dn_rem,
  output logic [RW-1:0] dn_den,
  output logic [QW-1:0] dn_quo
);

  logic          v_r;
  logic [RW-1:0] rem_r, rem_nxt, den_r;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [RW:0]   trial, diff;
  logic          ge;

  // One restoring step: shift in a zero (unless SHIFT is clear), subtract when the divisor fits
  generate
    if (SHIFT) begin : g_shift
      assign trial = {up_rem, 1'b0};
    end else begin : g_noshift
      assign trial = {1'b0, up_rem};
    end
  endgenerate

  assign diff    = trial - {1'b0, up_den};
  assign ge      = (trial >= {1'b0, up_den});
  assign rem_nxt = ge ? diff[RW-1:0] : trial[RW-1:0];
  assign quo_nxt = {up_quo[QW-2:0], ge};

  assign up_take = !v_r || down_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_take) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      rem_r <= rem_nxt;
      den_r <= up_den;
      quo_r <= quo_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_rem   = rem_r;
  assign dn_den   = den_r;
  assign dn_quo   = quo_r;

endmodule

>>> hw/rtl/slope_ratio_flux_limiter.sv
// Pipeline: three operand stages, then one divider cell per quotient bit,
//   FRAC_BITS+4 register stages in all.
// Throughput: one transaction per cycle while out_ready is high; each divider
//   cell resolves one bit.
// Reset (rst_n low, synchronous): every stage is emptied and the limiter
//   select returns to minbee. No clearing pass is needed.
module slope_ratio_flux_limiter #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_left_value,
  input  logic signed [VALUE_WIDTH-1:0] in_centre_value,
  input  logic signed [VALUE_WIDTH-1:0] in_right_value,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FRAC_BITS:0]            out_limiter_value
);
  import srfl_pkg::*;

  // Divider operands: magnitudes grow by one bit, their sum by one more
  localparam int DW = VALUE_WIDTH + 2;
  // Quotient lies in 0 .. 1.0 in Q1.FRAC_BITS
  localparam int QW = FRAC_BITS + 1;
  // One cell per quotient bit, the first without the shift
  localparam int NC = QW;

  lim_sel_t lim_sel_r;

  // Write the limiter select; the data is a single bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_sel_r <= LIM_MINBEE;
    end else if (cfg_wr_en) begin
      lim_sel_r <= lim_sel_t'(cfg_wr_data);
    end
  end

  // Links along the chain; index k feeds cell k, index NC is the output
  logic          c_valid [0:NC];
  logic          c_take  [0:NC];
  logic [DW-1:0] c_rem   [0:NC];
  logic [DW-1:0] c_den   [0:NC];
  logic [QW-1:0] c_quo   [0:NC];

  // Form differences, magnitudes and the numerator / denominator pair.
  // Minbee uses a/b below one and 2b/(a+b) above; van Leer uses
  // 2*min(a,b)/(a+b). Both keep numerator <= denominator, so the quotient
  // never exceeds 1.0.
  srfl_front #(
    .VW (VALUE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .lim_sel      (lim_sel_r),
    .up_valid     (in_valid),
    .up_take      (in_ready),
    .left_value   (in_left_value),
    .centre_value (in_centre_value),
    .right_value  (in_right_value),
    .down_take    (c_take[0]),
    .dn_valid     (c_valid[0]),
    .dn_num       (c_rem[0]),
    .dn_den       (c_den[0])
  );

  assign c_quo[0] = '0;

  // Restoring division, one quotient bit per cell, most significant first.
  // Each cell holds one transaction and hands it on whenever the next
  // cell can take it, so bubbles close up behind a stalled result.
  genvar k;
  generate
    for (k = 0; k < NC; k++) begin : g_cell
      srfl_div_cell #(
        .RW    (DW),
        .QW    (QW),
        .SHIFT (k != 0)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (c_valid[k]),
        .up_take   (c_take[k]),
        .up_rem    (c_rem[k]),
        .up_den    (c_den[k]),
        .up_quo    (c_quo[k]),
        .down_take (c_take[k+1]),
        .dn_valid  (c_valid[k+1]),
        .dn_rem    (c_rem[k+1]),
        .dn_den    (c_den[k+1]),
        .dn_quo    (c_quo[k+1])
      );
    end
  endgenerate

  // The last cell's registers act as the output register
  assign c_take[NC]        = out_ready;
  assign out_valid         = c_valid[NC];
  assign out_limiter_value = c_quo[NC];

  // A ready sink drains every stage, so the input must be open
  a_ready_path : assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while the result side is ready");

  // The limiter never exceeds 1.0
  a_result_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_limiter_value <= (QW'(1) << FRAC_BITS)))
    else $error("limiter value above 1.0");

  // Reset empties the chain
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // A remainder always stays below its divisor once a bit is resolved
  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (c_rem[NC] < c_den[NC]))
    else $error("divider remainder not below divisor");

endmodule
